// ===== src/q2e_pkg.sv =====
// Shared types and constants for the quaternion to Euler angle core.
// No dependencies.
package q2e_pkg;

    localparam int Q2E_IW           = 32;
    localparam int Q2E_PW           = 34;
    localparam int Q2E_VW           = 38;
    localparam int Q2E_CW           = 42;
    localparam int Q2E_ZW           = 35;
    localparam int Q2E_RW           = 61;
    localparam int Q2E_SW           = 62;
    localparam int Q2E_SQRT_STEPS   = 31;
    localparam int Q2E_LANES        = 3;
    localparam int Q2E_MAX_STAGES   = 30;
    localparam int Q2E_CORDIC_STAGES = 16;
    localparam int Q2E_PRODW        = 47;
    localparam int Q2E_DEG_SCALE    = 5730;

    localparam int Q2E_LANE_ROLL  = 0;
    localparam int Q2E_LANE_PITCH = 1;
    localparam int Q2E_LANE_YAW   = 2;

    localparam logic signed [Q2E_ZW-1:0] Q2E_PI = 35'sd3373259426;

    localparam logic signed [Q2E_ZW-1:0] Q2E_ATAN_TAB [0:Q2E_MAX_STAGES-1] = '{
        35'sh3243F6A8, 35'sh1DAC6705, 35'sh0FADBAFC, 35'sh07F56EA6, 35'sh03FEAB76,
        35'sh01FFD55B, 35'sh00FFFAAA, 35'sh007FFF55, 35'sh003FFFEA, 35'sh001FFFFD,
        35'sh000FFFFF, 35'sh0007FFFF, 35'sh0003FFFF, 35'sh0001FFFF, 35'sh0000FFFF,
        35'sh00007FFF, 35'sh00003FFF, 35'sh00001FFF, 35'sh00000FFF, 35'sh000007FF,
        35'sh000003FF, 35'sh000001FF, 35'sh000000FF, 35'sh0000007F, 35'sh0000003F,
        35'sh0000001F, 35'sh0000000F, 35'sh00000007, 35'sh00000003, 35'sh00000001
    };

    typedef struct packed {
        logic signed [Q2E_IW-1:0] s;
        logic signed [Q2E_VW-1:0] roll_y;
        logic signed [Q2E_VW-1:0] roll_x;
        logic signed [Q2E_VW-1:0] yaw_y;
        logic signed [Q2E_VW-1:0] yaw_x;
    } q2e_side_t;

    typedef struct packed {
        logic [Q2E_RW-1:0] v;
        logic [Q2E_SW-1:0] res;
        q2e_side_t         side;
    } q2e_sqrt_t;

    typedef struct packed {
        logic signed [Q2E_CW-1:0] x;
        logic signed [Q2E_CW-1:0] y;
        logic signed [Q2E_ZW-1:0] z;
        logic                     zero;
    } q2e_lane_t;

    typedef q2e_lane_t [Q2E_LANES-1:0] q2e_vec_t;

endpackage

// ===== src/q2e_if.sv =====
// Stream interfaces for quaternion beats in and Euler angle beats out.
// No dependencies.
interface q2e_quat_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic               quat_valid;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, quat_valid, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, quat_valid, output ready);
endinterface

interface q2e_euler_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_centideg;
    logic signed [14:0] pitch_centideg;
    logic signed [15:0] yaw_centideg;

    modport source (output valid, roll_centideg, pitch_centideg, yaw_centideg, input ready);
    modport sink   (input valid, roll_centideg, pitch_centideg, yaw_centideg, output ready);
endinterface

// ===== src/q2e_front.sv =====
// Front end: Q4.30 products of Q2.30 inputs, sums with asin clamp, and 2^60 - s^2 radicand.
// Depends on q2e_pkg.
module q2e_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [31:0]            w,
    input  logic signed [31:0]            x,
    input  logic signed [31:0]            y,
    input  logic signed [31:0]            z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output q2e_pkg::q2e_sqrt_t            out_data
);
    import q2e_pkg::*;

    typedef logic signed [Q2E_PW-1:0] prod_t;

    logic [2:0] v_reg;
    logic [2:0] adv;

    prod_t wy_reg, xz_reg, yz_reg, wx_reg, xx_reg, yy_reg, xy_reg, wz_reg, ww_reg, zz_reg;
    q2e_side_t side_reg, side_next;
    q2e_sqrt_t sq_reg;

    logic signed [Q2E_VW-1:0] s_full;
    logic [Q2E_IW-2:0]        s_abs;
    logic [Q2E_SW-1:0]        s_sq;

    function automatic prod_t mulq(input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[63:30];
    endfunction

    assign adv[2] = !v_reg[2] || out_ready;
    assign adv[1] = !v_reg[1] || adv[2];
    assign adv[0] = !v_reg[0] || adv[1];
    assign in_ready = adv[0];

    always_comb
    begin
        s_full = 38'sd2 * (Q2E_VW'(wy_reg) - Q2E_VW'(xz_reg));
        side_next.s = (s_full > 38'sd1073741824) ? 32'sd1073741824 :
                      (s_full < -38'sd1073741824) ? -32'sd1073741824 : Q2E_IW'(s_full);
        side_next.roll_y = 38'sd2 * (Q2E_VW'(yz_reg) + Q2E_VW'(wx_reg));
        side_next.roll_x = 38'sd1073741824 - 38'sd2 * (Q2E_VW'(xx_reg) + Q2E_VW'(yy_reg));
        side_next.yaw_y  = 38'sd2 * (Q2E_VW'(xy_reg) + Q2E_VW'(wz_reg));
        side_next.yaw_x  = Q2E_VW'(ww_reg) + Q2E_VW'(xx_reg) - Q2E_VW'(yy_reg)
                           - Q2E_VW'(zz_reg);
    end

    assign s_abs = side_reg.s[Q2E_IW-1] ? (Q2E_IW-1)'(-side_reg.s) : side_reg.s[Q2E_IW-2:0];
    assign s_sq  = Q2E_SW'(s_abs) * Q2E_SW'(s_abs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0]) v_reg[0] <= in_valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            wy_reg <= mulq(w, y);
            xz_reg <= mulq(x, z);
            yz_reg <= mulq(y, z);
            wx_reg <= mulq(w, x);
            xx_reg <= mulq(x, x);
            yy_reg <= mulq(y, y);
            xy_reg <= mulq(x, y);
            wz_reg <= mulq(w, z);
            ww_reg <= mulq(w, w);
            zz_reg <= mulq(z, z);
        end
        if (adv[1] && v_reg[0])
            side_reg <= side_next;
        if (adv[2] && v_reg[1])
        begin
            sq_reg.v    <= Q2E_RW'((Q2E_SW'(1) << 60) - s_sq);
            sq_reg.res  <= '0;
            sq_reg.side <= side_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign out_data  = sq_reg;
endmodule

// ===== src/q2e_sqrt_cell.sv =====
// One cell of the integer square root chain: tests one result bit per beat.
// Depends on q2e_pkg.
module q2e_sqrt_cell #(
    parameter int BIT_POS = 60
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  q2e_pkg::q2e_sqrt_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output q2e_pkg::q2e_sqrt_t out_data
);
    import q2e_pkg::*;

    logic      v_reg;
    q2e_sqrt_t d_reg, d_next;
    logic [Q2E_SW-1:0] bitv, trial;

    assign in_ready = !v_reg || out_ready;
    assign bitv  = Q2E_SW'(1) << BIT_POS;
    assign trial = in_data.res + bitv;

    always_comb
    begin
        d_next = in_data;
        if (Q2E_SW'(in_data.v) >= trial)
        begin
            d_next.v   = Q2E_RW'(Q2E_SW'(in_data.v) - trial);
            d_next.res = (in_data.res >> 1) + bitv;
        end
        else
        begin
            d_next.res = in_data.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            d_reg <= d_next;
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;
endmodule

// ===== src/q2e_cordic_cell.sv =====
// One vectoring CORDIC micro-rotation for the roll, pitch and yaw lanes.
// Depends on q2e_pkg.
module q2e_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  q2e_pkg::q2e_vec_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output q2e_pkg::q2e_vec_t out_data
);
    import q2e_pkg::*;

    logic     v_reg;
    q2e_vec_t d_reg, d_next;

    assign in_ready = !v_reg || out_ready;

    always_comb
    begin
        for (int l = 0; l < Q2E_LANES; l++)
        begin
            d_next[l].zero = in_data[l].zero;
            if (!in_data[l].y[Q2E_CW-1])
            begin
                d_next[l].x = in_data[l].x + (in_data[l].y >>> STAGE);
                d_next[l].y = in_data[l].y - (in_data[l].x >>> STAGE);
                d_next[l].z = in_data[l].z + Q2E_ATAN_TAB[STAGE];
            end
            else
            begin
                d_next[l].x = in_data[l].x - (in_data[l].y >>> STAGE);
                d_next[l].y = in_data[l].y + (in_data[l].x >>> STAGE);
                d_next[l].z = in_data[l].z - Q2E_ATAN_TAB[STAGE];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            d_reg <= d_next;
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;
endmodule

// ===== src/quaternion_to_euler_angles_core.sv =====
// Quaternion to roll/pitch/yaw core. Pipeline: front end, the 31 square root cells,
// pre-rotation register, CORDIC cell row, then scaling and output registers.
// Throughput: one beat per cycle; each stage stalls only when its successor is full and cannot advance.
// Beats with quat_valid clear are taken and dropped, giving no result.
// Reset (rst_n low, asynchronous) empties every stage; no data is cleared.
// Depends on q2e_pkg, q2e_if, q2e_front, q2e_sqrt_cell, q2e_cordic_cell.
module quaternion_to_euler_angles_core #(
    parameter int CORDIC_STAGES = q2e_pkg::Q2E_CORDIC_STAGES
) (
    input  logic          clk,
    input  logic          rst_n,
    q2e_quat_if.sink      quat,
    q2e_euler_if.source   euler
);
    import q2e_pkg::*;

    logic      sq_valid [0:Q2E_SQRT_STEPS];
    logic      sq_ready [0:Q2E_SQRT_STEPS];
    q2e_sqrt_t sq_data  [0:Q2E_SQRT_STEPS];

    logic     cd_valid [0:CORDIC_STAGES];
    logic     cd_ready [0:CORDIC_STAGES];
    q2e_vec_t cd_data  [0:CORDIC_STAGES];

    logic     pre_v_reg, scl_v_reg, out_v_reg;
    logic     pre_adv, scl_adv, out_adv;
    q2e_vec_t pre_reg, pre_next;
    logic [Q2E_PRODW-1:0] prod_reg [Q2E_LANES];
    logic [Q2E_LANES-1:0] neg_reg;
    logic signed [15:0] roll_reg, yaw_reg;
    logic signed [14:0] pitch_reg;
    logic signed [17:0] ang [Q2E_LANES];

    logic front_ready;
    assign quat.ready = front_ready;

    q2e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (quat.valid && quat.quat_valid),
        .in_ready  (front_ready),
        .w         (quat.quat_w),
        .x         (quat.quat_x),
        .y         (quat.quat_y),
        .z         (quat.quat_z),
        .out_valid (sq_valid[0]),
        .out_ready (sq_ready[0]),
        .out_data  (sq_data[0])
    );

    for (genvar k = 0; k < Q2E_SQRT_STEPS; k++)
    begin : g_sqrt
        q2e_sqrt_cell #(.BIT_POS(60 - 2 * k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[k]),
            .in_ready  (sq_ready[k]),
            .in_data   (sq_data[k]),
            .out_valid (sq_valid[k+1]),
            .out_ready (sq_ready[k+1]),
            .out_data  (sq_data[k+1])
        );
    end

    // pre-rotation: left half plane folded by +/-pi
    always_comb
    begin
        q2e_side_t sd;
        sd = sq_data[Q2E_SQRT_STEPS].side;
        pre_next[Q2E_LANE_ROLL].x  = Q2E_CW'(sd.roll_x);
        pre_next[Q2E_LANE_ROLL].y  = Q2E_CW'(sd.roll_y);
        pre_next[Q2E_LANE_PITCH].x = Q2E_CW'($signed({1'b0, sq_data[Q2E_SQRT_STEPS].res[31:0]}));
        pre_next[Q2E_LANE_PITCH].y = Q2E_CW'(sd.s);
        pre_next[Q2E_LANE_YAW].x   = Q2E_CW'(sd.yaw_x);
        pre_next[Q2E_LANE_YAW].y   = Q2E_CW'(sd.yaw_y);
        for (int l = 0; l < Q2E_LANES; l++)
        begin
            pre_next[l].zero = (pre_next[l].x == '0) && (pre_next[l].y == '0);
            pre_next[l].z    = '0;
            if (pre_next[l].x[Q2E_CW-1])
            begin
                pre_next[l].z = pre_next[l].y[Q2E_CW-1] ? -Q2E_PI : Q2E_PI;
                pre_next[l].x = -pre_next[l].x;
                pre_next[l].y = -pre_next[l].y;
            end
        end
    end

    assign pre_adv = !pre_v_reg || cd_ready[0];
    assign sq_ready[Q2E_SQRT_STEPS] = pre_adv;
    assign cd_valid[0] = pre_v_reg;
    assign cd_data[0]  = pre_reg;

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        q2e_cordic_cell #(.STAGE(k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cd_valid[k]),
            .in_ready  (cd_ready[k]),
            .in_data   (cd_data[k]),
            .out_valid (cd_valid[k+1]),
            .out_ready (cd_ready[k+1]),
            .out_data  (cd_data[k+1])
        );
    end

    assign out_adv = !out_v_reg || euler.ready;
    assign scl_adv = !scl_v_reg || out_adv;
    assign cd_ready[CORDIC_STAGES] = scl_adv;

    always_comb
    begin
        for (int l = 0; l < Q2E_LANES; l++)
        begin
            if (neg_reg[l])
                ang[l] = -$signed({1'b0, prod_reg[l][Q2E_PRODW-1:30]});
            else
                ang[l] = $signed({1'b0, prod_reg[l][Q2E_PRODW-1:30]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_v_reg <= 1'b0;
            scl_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (pre_adv) pre_v_reg <= sq_valid[Q2E_SQRT_STEPS];
            if (scl_adv) scl_v_reg <= cd_valid[CORDIC_STAGES];
            if (out_adv) out_v_reg <= scl_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pre_adv && sq_valid[Q2E_SQRT_STEPS])
            pre_reg <= pre_next;
        if (scl_adv && cd_valid[CORDIC_STAGES])
        begin
            for (int l = 0; l < Q2E_LANES; l++)
            begin
                logic signed [Q2E_ZW-1:0] zv;
                logic [Q2E_ZW-1:0]        mag;
                zv  = cd_data[CORDIC_STAGES][l].zero ? '0 : cd_data[CORDIC_STAGES][l].z;
                mag = zv[Q2E_ZW-1] ? Q2E_ZW'(-zv) : Q2E_ZW'(zv);
                neg_reg[l]  <= zv[Q2E_ZW-1];
                prod_reg[l] <= Q2E_PRODW'(mag) * Q2E_PRODW'(Q2E_DEG_SCALE);
            end
        end
        if (out_adv && scl_v_reg)
        begin
            roll_reg  <= ang[Q2E_LANE_ROLL][15:0];
            pitch_reg <= ang[Q2E_LANE_PITCH][14:0];
            yaw_reg   <= ang[Q2E_LANE_YAW][15:0];
        end
    end

    assign euler.valid          = out_v_reg;
    assign euler.roll_centideg  = roll_reg;
    assign euler.pitch_centideg = pitch_reg;
    assign euler.yaw_centideg   = yaw_reg;

    a_pre_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        pre_v_reg |-> !pre_reg[Q2E_LANE_ROLL].x[Q2E_CW-1]
                   && !pre_reg[Q2E_LANE_PITCH].x[Q2E_CW-1]
                   && !pre_reg[Q2E_LANE_YAW].x[Q2E_CW-1])
        else $error("pre-rotation left a vector in the left half plane");

    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        pre_v_reg && pre_reg[Q2E_LANE_PITCH].zero |-> pre_reg[Q2E_LANE_PITCH].z == '0)
        else $error("zero vector with nonzero start angle");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid |-> euler.pitch_centideg <= 15'sd9100
                     && euler.pitch_centideg >= -15'sd9100)
        else $error("pitch beyond quarter turn");

    a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid[Q2E_SQRT_STEPS] |-> sq_data[Q2E_SQRT_STEPS].res[Q2E_SW-1:31] == '0)
        else $error("square root result exceeds Q.30 one");
endmodule

// ===== verif/quaternion_to_euler_angles_core_test.sv =====
// Testbench for quaternion_to_euler_angles_core: directed and random quaternion beats,
// a bit-exact fixed-point predictor and an in-order scoreboard of expected angles.
// Depends on q2e_pkg, q2e_if and the core RTL.
module quaternion_to_euler_angles_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import q2e_pkg::*;

    typedef struct {
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               flag;
    } quat_t;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
    } euler_t;

    class euler_scoreboard;
        euler_t pending[$];
        int     errors = 0;

        function longint mulq(longint a, longint b);
            return (a * b) >>> 30;
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function longint cordic_atan2(longint y, longint x);
            longint ang;
            longint dx;
            longint dy;
            ang = 0;
            if (x == 0 && y == 0)
                return 0;
            if (x < 0)
            begin
                ang = (y >= 0) ? longint'(Q2E_PI) : -longint'(Q2E_PI);
                x = -x;
                y = -y;
            end
            for (int i = 0; i < Q2E_CORDIC_STAGES && i < Q2E_MAX_STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    ang = ang + longint'(Q2E_ATAN_TAB[i]);
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    ang = ang - longint'(Q2E_ATAN_TAB[i]);
                end
            end
            return ang;
        endfunction

        function longint centideg(longint ang);
            longint unsigned m;
            m = (ang < 0) ? longint'(-ang) : longint'(ang);
            m = (m * Q2E_DEG_SCALE) >> 30;
            return (ang < 0) ? -longint'(m) : longint'(m);
        endfunction

        function euler_t predict(quat_t q);
            longint w, x, y, z, s, c;
            longint unsigned s2;
            euler_t e;
            longint r;
            w = q.w; x = q.x; y = q.y; z = q.z;
            s = 2 * (mulq(w, y) - mulq(x, z));
            if (s > (64'sd1 << 30))
                s = 64'sd1 << 30;
            if (s < -(64'sd1 << 30))
                s = -(64'sd1 << 30);
            s2 = (s < 0) ? -s : s;
            s2 = s2 * s2;
            c = isqrt((64'd1 << 60) - s2);
            r = centideg(cordic_atan2(s, c));
            e.pitch = r[14:0];
            r = centideg(cordic_atan2(2 * (mulq(y, z) + mulq(w, x)),
                                      (64'sd1 << 30) - 2 * (mulq(x, x) + mulq(y, y))));
            e.roll = r[15:0];
            r = centideg(cordic_atan2(2 * (mulq(x, y) + mulq(w, z)),
                                      mulq(w, w) + mulq(x, x) - mulq(y, y) - mulq(z, z)));
            e.yaw = r[15:0];
            return e;
        endfunction

        function void note_quat(quat_t q);
            if (q.flag)
                pending.push_back(predict(q));
        endfunction

        function void check_euler(euler_t got);
            euler_t exp_e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat roll=%0d pitch=%0d yaw=%0d",
                         $time, got.roll, got.pitch, got.yaw);
                return;
            end
            exp_e = pending.pop_front();
            if (got.roll !== exp_e.roll)
            begin
                errors++;
                $display("%0t: roll expected %0d actual %0d", $time, exp_e.roll, got.roll);
            end
            if (got.pitch !== exp_e.pitch)
            begin
                errors++;
                $display("%0t: pitch expected %0d actual %0d", $time, exp_e.pitch, got.pitch);
            end
            if (got.yaw !== exp_e.yaw)
            begin
                errors++;
                $display("%0t: yaw expected %0d actual %0d", $time, exp_e.yaw, got.yaw);
            end
        endfunction
    endclass

    localparam int LATENCY = 3 + 31 + 1 + Q2E_CORDIC_STAGES + 2;
    localparam int IDLE_LIMIT = 5000;
    localparam int ONE = 1 << 30;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   idle_cycles = 0;
    int   rx_cycle = 0;
    int   burst_left = 0;

    q2e_quat_if  quat ();
    q2e_euler_if euler ();

    euler_scoreboard sb = new();

    quaternion_to_euler_angles_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .quat  (quat.sink),
        .euler (euler.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        quat.valid = 1'b0;
        quat.quat_w = '0;
        quat.quat_x = '0;
        quat.quat_y = '0;
        quat.quat_z = '0;
        quat.quat_valid = 1'b0;
        euler.ready = 1'b0;
    end

    // receiver: own stall pattern plus one long hold-off
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle >= 150 && rx_cycle < 450)
            euler.ready <= 1'b0;
        else if ((rx_cycle / 200) % 3 == 0)
            euler.ready <= 1'b1;
        else
            euler.ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && euler.valid && euler.ready)
            sb.check_euler(euler_t'{euler.roll_centideg, euler.pitch_centideg,
                                    euler.yaw_centideg});
    end

    always @(posedge clk)
    begin
        if ((quat.valid && quat.ready) || (euler.valid && euler.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL quaternion_to_euler_angles_core");
            $finish;
        end
    end

    task automatic send_quat(quat_t q);
        int gap;
        quat.valid <= 1'b1;
        quat.quat_w <= q.w;
        quat.quat_x <= q.x;
        quat.quat_y <= q.y;
        quat.quat_z <= q.z;
        quat.quat_valid <= q.flag;
        do
            @(posedge clk);
        while (!quat.ready);
        sb.note_quat(q);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                quat.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic quat_t unit_quat();
        real a, b, c, d, n;
        quat_t q;
        a = $itor($signed($urandom)) / 2147483648.0;
        b = $itor($signed($urandom)) / 2147483648.0;
        c = $itor($signed($urandom)) / 2147483648.0;
        d = $itor($signed($urandom)) / 2147483648.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0e-6)
        begin
            a = 1.0;
            n = 1.0;
        end
        q.w = $rtoi(a / n * 1073741823.0);
        q.x = $rtoi(b / n * 1073741823.0);
        q.y = $rtoi(c / n * 1073741823.0);
        q.z = $rtoi(d / n * 1073741823.0);
        q.flag = 1'b1;
        return q;
    endfunction

    initial
    begin
        quat_t q;
        quat_t dir[$];
        int kind;
        int guard;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir.push_back('{0, 0, 0, 0, 1'b1});                       // zero vector
        dir.push_back('{ONE, 0, 0, 0, 1'b1});                     // identity
        dir.push_back('{0, ONE, 0, 0, 1'b1});                     // roll on negative x axis
        dir.push_back('{0, -ONE, 0, 0, 1'b1});
        dir.push_back('{0, 0, 0, ONE, 1'b1});                     // yaw on negative x axis
        dir.push_back('{0, 0, ONE, 0, 1'b1});
        dir.push_back('{ONE, 0, ONE, 0, 1'b1});                   // pitch clamp high
        dir.push_back('{ONE, 0, -ONE, 0, 1'b1});                  // pitch clamp low
        dir.push_back('{ONE / 2, ONE / 2, ONE / 2, ONE / 2, 1'b1});
        dir.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1});
        dir.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1});
        dir.push_back('{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1'b1});
        dir.push_back('{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1});
        dir.push_back('{-1, -1, -1, -1, 1'b1});
        dir.push_back('{1, 1, 1, 1, 1'b1});
        dir.push_back('{32'sh7FFFFFFF, 0, 0, 0, 1'b0});           // flag clear
        dir.push_back('{-ONE, 0, 0, 0, 1'b1});
        dir.push_back('{0, 0, 0, 0, 1'b0});
        foreach (dir[i])
            send_quat(dir[i]);

        for (int n = 0; n < 500; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
                q = unit_quat();
            else if (kind < 80)
            begin
                q.w = $urandom_range(0, 2 * ONE) - ONE;
                q.x = $urandom_range(0, 2 * ONE) - ONE;
                q.y = $urandom_range(0, 2 * ONE) - ONE;
                q.z = $urandom_range(0, 2 * ONE) - ONE;
                q.flag = 1'b1;
            end
            else
            begin
                q.w = $urandom;
                q.x = $urandom;
                q.y = $urandom;
                q.z = $urandom;
                q.flag = (kind < 92);
            end
            send_quat(q);
        end
        quat.valid <= 1'b0;

        guard = 0;
        while (sb.pending.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (2 * LATENCY) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS quaternion_to_euler_angles_core");
        else
            $display("FAIL quaternion_to_euler_angles_core");
        $finish;
    end
endmodule

// ===== sim.f =====
src/q2e_pkg.sv
src/q2e_if.sv
src/q2e_front.sv
src/q2e_sqrt_cell.sv
src/q2e_cordic_cell.sv
src/quaternion_to_euler_angles_core.sv
verif/quaternion_to_euler_angles_core_test.sv
